[rtl/etps_pkg.sv]
// Shared types and constants for the envelope triggered pitch sweep block.
package etps_pkg;

    localparam int TUNE_W  = 24;
    localparam int ENV_W   = 25;
    localparam int COEF_W  = 16;
    localparam int RATIO_W = 24;
    localparam int PHASE_W = 2;
    localparam int MODE_W  = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 25;
    localparam int MUL_A_W = ENV_W;
    localparam int MUL_B_W = TUNE_W;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    localparam logic [TUNE_W-1:0]  ONE_Q23 = 24'd8388608;
    localparam logic [RATIO_W-1:0] ONE_Q22 = 24'd4194304;

    typedef enum logic [MODE_W-1:0] {
        MODE_TRIGGERED = 2'd0,
        MODE_WHAMMY    = 2'd1,
        MODE_INVERTED  = 2'd2,
        MODE_FREE      = 2'd3
    } mode_t;

    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE   = 2'd0,
        PH_RISING = 2'd1,
        PH_HOLD   = 2'd2,
        PH_FALL   = 2'd3
    } phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE          = 3'd0,
        CFG_THRESHOLD     = 3'd1,
        CFG_ATTACK_STEP   = 3'd2,
        CFG_DECAY_STEP    = 3'd3,
        CFG_ENV_COEF      = 3'd4,
        CFG_WHAMMY_LEVEL  = 3'd5,
        CFG_PITCH_RANGE   = 3'd6,
        CFG_INTERVAL_ZERO = 3'd7
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAG,
        ST_ENV_MUL,
        ST_ENV_UPD,
        ST_CMP,
        ST_RAMP,
        ST_USE_MUL,
        ST_RATIO_MUL,
        ST_DONE
    } state_t;

endpackage

[rtl/envelope_triggered_pitch_sweep_top.sv]
// Envelope triggered pitch sweep controller with one shared multiplier.
//
//  channel   | direction | tdata fields (lowest bit up)
//  s_axis    | in        | left_sample, right_sample
//  m_axis    | out       | mono_sample, tune_level, sweep_phase, pitch_ratio
//  cfg       | in        | cfg_index selects register, cfg_data holds value
//
// Modes 0 and 2 run MAG, ENV_MUL, ENV_UPD, CMP, RAMP, USE_MUL, RATIO_MUL and
// DONE, modes 1 and 3 skip ENV_MUL to RAMP, then back to idle; the single
// multiplier does envelope release, tune times whammy, ratio scaling in turn.
// Reset clears the envelope, tune level and phase and loads register defaults.
// s_axis_tready is high only in idle; a stalled result holds the sequencer
// in its last step until the output register is free.
module envelope_triggered_pitch_sweep_top
    import etps_pkg::*;
#(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // left_sample, right_sample
    input  logic [((2 * SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // mono_sample, tune_level, sweep_phase, pitch_ratio
    output logic [((SAMPLE_BITS + TUNE_W + PHASE_W + RATIO_W + 7) / 8) * 8 - 1:0] m_axis_tdata,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int OUT_RAW_W = SAMPLE_BITS + TUNE_W + PHASE_W + RATIO_W;
    localparam int OUT_W = ((OUT_RAW_W + 7) / 8) * 8;
    localparam int SHL = (SAMPLE_BITS < 24) ? (24 - SAMPLE_BITS) : 0;
    localparam int SHR = (SAMPLE_BITS > 24) ? (SAMPLE_BITS - 24) : 0;
    localparam int MW  = SAMPLE_BITS + SHL;

    // configuration registers
    mode_t              mode_reg;
    logic [ENV_W-1:0]   thr_reg;
    logic [TUNE_W-1:0]  attack_reg;
    logic [TUNE_W-1:0]  decay_reg;
    logic [COEF_W-1:0]  coef_reg;
    logic [TUNE_W-1:0]  whammy_reg;
    logic [RATIO_W-1:0] range_reg;
    logic               izero_reg;

    // sequencer and state
    state_t state_reg, state_next;
    logic [ENV_W-1:0]  env_reg, env_next;
    logic [TUNE_W-1:0] tune_reg, tune_next;
    phase_t            phase_reg, phase_next;

    // working registers
    logic signed [SAMPLE_BITS-1:0] l_reg, r_reg;
    logic [SAMPLE_BITS-1:0] mono_reg, mono_next;
    logic [ENV_W-1:0]  sum_reg, sum_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic le_tz_reg, ge_thr_reg, lt_td_reg;
    logic le_tz_next, ge_thr_next, lt_td_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]   out_data_reg, out_data_next;

    // datapath signals
    logic signed [SAMPLE_BITS:0] lr_sum;
    logic [SAMPLE_BITS-1:0] abs_l, abs_r;
    logic [MW-1:0] ext_l, ext_r;
    logic [TUNE_W-1:0] mag_l, mag_r;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [PROD_W-1:0]  mul_p;
    logic [PROD_W:0]    prod_rnd23, prod_rnd16;
    logic [ENV_W-1:0]   env_dec;
    logic [ENV_W+1:0]   thr_x3;
    logic [TUNE_W-1:0]  wh_sat, use_val;
    logic [RATIO_W-1:0] rng_mag;
    logic               rng_neg;
    logic [ENV_W-1:0]   ratio_wide;
    logic [ENV_W-1:0]   ramp_t;
    phase_t             ramp_ph;
    logic               accept_in, out_free;

    assign accept_in = s_axis_tvalid && s_axis_tready;
    assign out_free  = !out_valid_reg || m_axis_tready;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_TRIGGERED;
            thr_reg    <= 25'd838861;
            attack_reg <= 24'd874;
            decay_reg  <= 24'd874;
            coef_reg   <= 16'd655;
            whammy_reg <= '0;
            range_reg  <= 24'd4194304;
            izero_reg  <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_MODE:          mode_reg   <= mode_t'(cfg_data[MODE_W-1:0]);
                CFG_THRESHOLD:     thr_reg    <= cfg_data[ENV_W-1:0];
                CFG_ATTACK_STEP:   attack_reg <= cfg_data[TUNE_W-1:0];
                CFG_DECAY_STEP:    decay_reg  <= cfg_data[TUNE_W-1:0];
                CFG_ENV_COEF:      coef_reg   <= cfg_data[COEF_W-1:0];
                CFG_WHAMMY_LEVEL:  whammy_reg <= cfg_data[TUNE_W-1:0];
                CFG_PITCH_RANGE:   range_reg  <= cfg_data[RATIO_W-1:0];
                CFG_INTERVAL_ZERO: izero_reg  <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // sample magnitudes and mono mix
    always_comb
    begin
        lr_sum = {l_reg[SAMPLE_BITS-1], l_reg} + {r_reg[SAMPLE_BITS-1], r_reg};
        abs_l  = l_reg[SAMPLE_BITS-1] ? SAMPLE_BITS'(-l_reg) : SAMPLE_BITS'(l_reg);
        abs_r  = r_reg[SAMPLE_BITS-1] ? SAMPLE_BITS'(-r_reg) : SAMPLE_BITS'(r_reg);
        ext_l  = MW'(abs_l) << SHL;
        ext_r  = MW'(abs_r) << SHL;
        mag_l  = TUNE_W'(ext_l >> SHR);
        mag_r  = TUNE_W'(ext_r >> SHR);
    end

    // shared multiplier operand select
    always_comb
    begin
        wh_sat  = (whammy_reg > ONE_Q23) ? ONE_Q23 : whammy_reg;
        rng_neg = (range_reg < ONE_Q22);
        rng_mag = rng_neg ? (ONE_Q22 - range_reg) : (range_reg - ONE_Q22);
        prod_rnd23 = {1'b0, prod_reg} + (PROD_W+1)'(ONE_Q23 >> 1);
        prod_rnd16 = {1'b0, prod_reg} + (PROD_W+1)'(32768);
        env_dec    = prod_rnd16[ENV_W+15:16];
        thr_x3     = {2'b00, thr_reg} + {1'b0, thr_reg, 1'b0};

        case (mode_reg)
            MODE_WHAMMY:    use_val = wh_sat;
            MODE_INVERTED:  use_val = ONE_Q23 - tune_reg;
            MODE_TRIGGERED: use_val = izero_reg ? prod_rnd23[TUNE_W+22:23] : tune_reg;
            default:        use_val = tune_reg;
        endcase

        case (state_reg)
            ST_ENV_MUL:
            begin
                mul_a = env_reg - sum_reg;
                mul_b = MUL_B_W'(coef_reg);
            end
            ST_USE_MUL:
            begin
                mul_a = MUL_A_W'(tune_reg);
                mul_b = wh_sat;
            end
            ST_RATIO_MUL:
            begin
                mul_a = MUL_A_W'(rng_mag);
                mul_b = use_val;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

        ratio_wide = rng_neg ? (ENV_W'(ONE_Q22) - prod_rnd23[ENV_W+22:23])
                             : (ENV_W'(ONE_Q22) + prod_rnd23[ENV_W+22:23]);
    end

    // ramp phase update
    always_comb
    begin
        ramp_ph = phase_reg;
        ramp_t  = ENV_W'(tune_reg);
        if (le_tz_reg)
        begin
            ramp_ph = PH_IDLE;
            ramp_t  = '0;
        end
        if (ramp_ph == PH_IDLE && ge_thr_reg)
        begin
            ramp_ph = PH_RISING;
        end
        if (ramp_ph == PH_RISING)
        begin
            ramp_t = ramp_t + ENV_W'(attack_reg);
            if (ramp_t >= ENV_W'(ONE_Q23))
            begin
                ramp_ph = PH_HOLD;
            end
        end
        if (ramp_ph == PH_HOLD)
        begin
            ramp_t = ENV_W'(ONE_Q23);
            if (lt_td_reg)
            begin
                ramp_ph = PH_FALL;
            end
        end
        if (ramp_ph == PH_FALL)
        begin
            if (ENV_W'(decay_reg) >= ramp_t)
            begin
                ramp_t  = '0;
                ramp_ph = PH_IDLE;
            end
            else
            begin
                ramp_t = ramp_t - ENV_W'(decay_reg);
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept_in)
                begin
                    state_next = ST_MAG;
                end
            end
            ST_MAG:
            begin
                if (mode_reg == MODE_TRIGGERED || mode_reg == MODE_INVERTED)
                begin
                    state_next = ST_ENV_MUL;
                end
                else
                begin
                    state_next = ST_USE_MUL;
                end
            end
            ST_ENV_MUL:   state_next = ST_ENV_UPD;
            ST_ENV_UPD:   state_next = ST_CMP;
            ST_CMP:       state_next = ST_RAMP;
            ST_RAMP:      state_next = ST_USE_MUL;
            ST_USE_MUL:   state_next = ST_RATIO_MUL;
            ST_RATIO_MUL: state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // datapath updates per step
    always_comb
    begin
        env_next       = env_reg;
        tune_next      = tune_reg;
        phase_next     = phase_reg;
        mono_next      = mono_reg;
        sum_next       = sum_reg;
        prod_next      = prod_reg;
        le_tz_next     = le_tz_reg;
        ge_thr_next    = ge_thr_reg;
        lt_td_next     = lt_td_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        case (state_reg)
            ST_MAG:
            begin
                mono_next = lr_sum[SAMPLE_BITS:1];
                sum_next  = ENV_W'(mag_l) + ENV_W'(mag_r);
            end
            ST_ENV_MUL, ST_USE_MUL, ST_RATIO_MUL:
            begin
                prod_next = mul_p;
            end
            ST_ENV_UPD:
            begin
                env_next = (sum_reg > env_reg) ? sum_reg : (env_reg - env_dec);
            end
            ST_CMP:
            begin
                le_tz_next  = (env_reg <= (thr_reg >> 1));
                ge_thr_next = (env_reg >= thr_reg);
                lt_td_next  = (env_reg < thr_x3[ENV_W+1:2]);
            end
            ST_RAMP:
            begin
                tune_next  = ramp_t[TUNE_W-1:0];
                phase_next = ramp_ph;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = OUT_W'({ratio_wide[RATIO_W-1:0], phase_reg,
                                             tune_reg, mono_reg});
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            env_reg       <= '0;
            tune_reg      <= '0;
            phase_reg     <= PH_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            env_reg       <= env_next;
            tune_reg      <= tune_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            l_reg <= s_axis_tdata[SAMPLE_BITS-1:0];
            r_reg <= s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
        end
        mono_reg     <= mono_next;
        sum_reg      <= sum_next;
        prod_reg     <= prod_next;
        le_tz_reg    <= le_tz_next;
        ge_thr_reg   <= ge_thr_next;
        lt_td_reg    <= lt_td_next;
        out_data_reg <= out_data_next;
    end

    a_tune_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tune_reg <= ONE_Q23)
        else $error("tune level above one");

    a_idle_tune_zero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE |-> tune_reg == '0)
        else $error("idle phase with nonzero tune");

    a_hold_tune_full: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_HOLD |-> tune_reg == ONE_Q23)
        else $error("hold phase without full tune");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept_in |=> state_reg == ST_MAG)
        else $error("accepted item did not start sequencer");

    a_env_bound: assert property (@(posedge clk) disable iff (!rst_n)
        env_reg <= ENV_W'(ONE_Q23) + ENV_W'(ONE_Q23))
        else $error("envelope above two");

endmodule

[sim/envelope_triggered_pitch_sweep_top_tb.sv]
// Testbench for the pitch sweep block: stereo bursts and noise checked against a predictor.
`timescale 1ns / 100ps

module envelope_triggered_pitch_sweep_top_tb
    import etps_pkg::*;
();

    localparam int IN_W  = 48;
    localparam int OUT_W = 80;
    localparam int CYCLE_LIMIT = 300000;
    localparam longint unsigned FULL_SCALE = 64'd8388608;

    typedef struct {
        logic [23:0] mono;
        logic [23:0] tune;
        phase_t      phase;
        logic [23:0] ratio;
    } sweep_out_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_W-1:0]       s_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_W-1:0]      m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic [IN_W-1:0] sample_queue[$];
    sweep_out_t      expected_sweeps[$];
    int              mismatch_cnt = 0;
    int              cycle_cnt = 0;
    logic            calm = 1'b0;

    mode_t       cfg_mode = MODE_TRIGGERED;
    logic [24:0] cfg_thr = 25'd838861;
    logic [23:0] cfg_attack = 24'd874;
    logic [23:0] cfg_decay = 24'd874;
    logic [15:0] cfg_coef = 16'd655;
    logic [23:0] cfg_whammy = 24'd0;
    logic [23:0] cfg_range = 24'd4194304;
    logic        cfg_izero = 1'b1;

    logic [24:0] env_q = '0;
    logic [23:0] tune_q = '0;
    phase_t      phase_q = PH_IDLE;

    envelope_triggered_pitch_sweep_top #(
        .SAMPLE_BITS(24)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic sweep_out_t sweep_step(logic [IN_W-1:0] item);
        logic signed [23:0] ls;
        logic signed [23:0] rs;
        longint             lsmp, rsmp, mono, diff, ratio;
        longint unsigned    sum, env, tune, tz, td, wh, use_lvl, mag, prod;
        phase_t             ph;
        sweep_out_t         res;
        ls = item[23:0];
        rs = item[47:24];
        lsmp = longint'(ls);
        rsmp = longint'(rs);
        mono = (lsmp + rsmp) >>> 1;
        sum = ((lsmp < 0) ? -lsmp : lsmp) + ((rsmp < 0) ? -rsmp : rsmp);
        if (cfg_mode == MODE_TRIGGERED || cfg_mode == MODE_INVERTED)
        begin
            env = 64'(env_q);
            tune = 64'(tune_q);
            ph = phase_q;
            tz = longint'(cfg_thr) >> 1;
            td = (longint'(cfg_thr) * 3) >> 2;
            if (sum > env)
                env = sum;
            else
                env = env - (((env - sum) * cfg_coef + 64'd32768) >> 16);
            if (env <= tz)
            begin
                ph = PH_IDLE;
                tune = 0;
            end
            if (ph == PH_IDLE && env >= cfg_thr)
                ph = PH_RISING;
            if (ph == PH_RISING)
            begin
                tune = tune + cfg_attack;
                if (tune >= ONE_Q23)
                    ph = PH_HOLD;
            end
            if (ph == PH_HOLD)
            begin
                tune = 64'(ONE_Q23);
                if (env < td)
                    ph = PH_FALL;
            end
            if (ph == PH_FALL)
            begin
                if (cfg_decay >= tune)
                begin
                    tune = 0;
                    ph = PH_IDLE;
                end
                else
                    tune = tune - cfg_decay;
            end
            env_q = env[24:0];
            tune_q = tune[23:0];
            phase_q = ph;
        end
        wh = 64'((cfg_whammy > ONE_Q23) ? ONE_Q23 : cfg_whammy);
        use_lvl = (cfg_mode == MODE_WHAMMY) ? wh : 64'(tune_q);
        if (cfg_mode == MODE_TRIGGERED && cfg_izero)
            use_lvl = (longint'(tune_q) * wh + 64'd4194304) >> 23;
        if (cfg_mode == MODE_INVERTED)
            use_lvl = longint'(ONE_Q23) - longint'(tune_q);
        diff = longint'(cfg_range) - longint'(ONE_Q22);
        mag = (diff < 0) ? -diff : diff;
        prod = (mag * use_lvl + 64'd4194304) >> 23;
        ratio = (diff < 0) ? longint'(ONE_Q22) - longint'(prod)
                           : longint'(ONE_Q22) + longint'(prod);
        res.mono = mono[23:0];
        res.tune = tune_q;
        res.phase = phase_q;
        res.ratio = ratio[23:0];
        return res;
    endfunction

    function automatic void field_check(string label, logic [23:0] want_v, logic [23:0] got_v);
        if (want_v !== got_v)
        begin
            mismatch_cnt++;
            $display("%0t: %s expected %h actual %h", $time, label, want_v, got_v);
        end
    endfunction

    function automatic void queue_item(logic [IN_W-1:0] item);
        sample_queue.insert(sample_queue.size(), item);
    endfunction

    function automatic logic [23:0] signed_sample(longint unsigned mag);
        if (mag == FULL_SCALE || (mag != 0 && $urandom_range(1) == 1))
            return 24'(-mag);
        return 24'(mag);
    endfunction

    function automatic logic [IN_W-1:0] stereo_at(longint unsigned level);
        longint unsigned lmag, lo, hi;
        if (level > 2 * FULL_SCALE)
            level = 2 * FULL_SCALE;
        lo = (level > FULL_SCALE) ? level - FULL_SCALE : 0;
        hi = (level > FULL_SCALE) ? FULL_SCALE : level;
        lmag = 64'($urandom_range(int'(hi), int'(lo)));
        return {signed_sample(level - lmag), signed_sample(lmag)};
    endfunction

    function automatic int unsigned skewed_value(int unsigned lo_end, int unsigned hi_end,
                                                 int unsigned span_lo, int unsigned span_hi);
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 12)
            return lo_end;
        if (pick < 24)
            return hi_end;
        return $urandom_range(span_hi, span_lo);
    endfunction

    // queue one burst (loud, middle, quiet), a run of noise or an extreme pair; return its length
    function automatic int queue_run();
        int              pick, n_loud, n_mid, n_quiet, i;
        longint unsigned thr, mid_lo, mid_hi;
        pick = $urandom_range(99);
        thr = 64'(cfg_thr);
        if (pick < 15)
        begin
            n_loud = $urandom_range(8, 1);
            for (i = 0; i < n_loud; i++)
                queue_item(IN_W'({$urandom(), $urandom()}));
            return n_loud;
        end
        if (pick < 20)
        begin
            queue_item({24'h800000, 24'h800000});
            queue_item({24'h7FFFFF, 24'h7FFFFF});
            return 2;
        end
        n_loud = $urandom_range(40, 1);
        n_mid = $urandom_range(30, 0);
        n_quiet = $urandom_range(15, 1);
        mid_lo = thr / 2 + 1;
        mid_hi = (thr * 3) / 4;
        if (mid_hi < mid_lo)
            mid_hi = mid_lo;
        for (i = 0; i < n_loud; i++)
            queue_item(stereo_at(thr + $urandom_range(4194304, 0)));
        for (i = 0; i < n_mid; i++)
            queue_item(stereo_at($urandom_range(int'(mid_hi), int'(mid_lo))));
        for (i = 0; i < n_quiet; i++)
            queue_item(stereo_at($urandom_range(int'(thr / 2), 0)));
        return n_loud + n_mid + n_quiet;
    endfunction

    task automatic drain();
        while (sample_queue.size() != 0 || expected_sweeps.size() != 0)
            @(negedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic cfg_write(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
    endtask

    task automatic write_all(mode_t m, logic [24:0] thr, logic [23:0] att, logic [23:0] dec,
                             logic [15:0] coef, logic [23:0] wh, logic [23:0] rng, logic iz);
        drain();
        cfg_write(CFG_MODE, CFG_DATA_W'(m));
        cfg_write(CFG_THRESHOLD, thr);
        cfg_write(CFG_ATTACK_STEP, CFG_DATA_W'(att));
        cfg_write(CFG_DECAY_STEP, CFG_DATA_W'(dec));
        cfg_write(CFG_ENV_COEF, CFG_DATA_W'(coef));
        cfg_write(CFG_WHAMMY_LEVEL, CFG_DATA_W'(wh));
        cfg_write(CFG_PITCH_RANGE, CFG_DATA_W'(rng));
        cfg_write(CFG_INTERVAL_ZERO, CFG_DATA_W'(iz));
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && cfg_wr_en)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_MODE:          cfg_mode = mode_t'(cfg_data[1:0]);
                CFG_THRESHOLD:     cfg_thr = cfg_data[24:0];
                CFG_ATTACK_STEP:   cfg_attack = cfg_data[23:0];
                CFG_DECAY_STEP:    cfg_decay = cfg_data[23:0];
                CFG_ENV_COEF:      cfg_coef = cfg_data[15:0];
                CFG_WHAMMY_LEVEL:  cfg_whammy = cfg_data[23:0];
                CFG_PITCH_RANGE:   cfg_range = cfg_data[23:0];
                CFG_INTERVAL_ZERO: cfg_izero = cfg_data[0];
                default:           ;
            endcase
        end
    end

    always @(posedge clk)
    begin
        logic taken;
        taken = s_tvalid && s_axis_tready;
        if (taken)
        begin
            expected_sweeps.insert(expected_sweeps.size(), sweep_step(s_tdata));
            void'(sample_queue.pop_front());
        end
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (taken || !s_tvalid)
        begin
            if (sample_queue.size() != 0 && (calm || $urandom_range(99) >= 7))
            begin
                s_tvalid <= 1'b1;
                s_tdata <= sample_queue[0];
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        sweep_out_t want;
        if (rst_n && m_axis_tvalid && m_tready)
        begin
            if (expected_sweeps.size() == 0)
            begin
                mismatch_cnt++;
                $display("%0t: unexpected item, expected none actual %h", $time, m_tdata[73:0]);
            end
            else
            begin
                want = expected_sweeps.pop_front();
                field_check("mono_sample", want.mono, m_tdata[23:0]);
                field_check("tune_level", want.tune, m_tdata[47:24]);
                field_check("sweep_phase", {22'd0, want.phase}, {22'd0, m_tdata[49:48]});
                field_check("pitch_ratio", want.ratio, m_tdata[73:50]);
            end
        end
        m_tready <= rst_n && (calm || $urandom_range(99) >= 7);
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("envelope_triggered_pitch_sweep_top_tb: errors");
            $finish;
        end
    end

    initial
    begin
        int    k, n, pick, i;
        mode_t rmode;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // defaults after reset, extreme sample pairs
        queue_item({24'h7FFFFF, 24'h7FFFFF});
        queue_item({24'h800000, 24'h800000});
        queue_item({24'h7FFFFF, 24'h800000});
        queue_item({24'h000000, 24'h000000});
        queue_item({24'hFFFFFF, 24'hFFFFFF});
        queue_item({24'hFFFFFF, 24'h000001});

        // full sweep: overshoot on rise, hold, fall below zero, reset to idle
        write_all(MODE_TRIGGERED, 25'd4194304, 24'd3000000, 24'd3000000, 16'd32768,
                  24'hFFFFFF, 24'd8388608, 1'b1);
        queue_item({24'h000000, 24'h000000});
        for (i = 0; i < 5; i++)
            queue_item({24'h400000, 24'h400000});
        for (i = 0; i < 6; i++)
            queue_item({24'd1258291, 24'd1258291});
        for (i = 0; i < 3; i++)
            queue_item({24'h000000, 24'h000000});

        write_all(MODE_WHAMMY, 25'd0, 24'hFFFFFF, 24'd0, 16'd0, 24'd8388608, 24'd0, 1'b0);
        queue_item({24'h123456, 24'h800000});
        queue_item({24'h7FFFFF, 24'hABCDEF});

        write_all(MODE_INVERTED, 25'h1FFFFFF, 24'd0, 24'hFFFFFF, 16'hFFFF, 24'd0,
                  24'hFFFFFF, 1'b1);
        queue_item({24'h800000, 24'h800000});
        queue_item({24'h7FFFFF, 24'h7FFFFF});

        write_all(MODE_FREE, 25'd0, 24'd8388608, 24'd8388608, 16'hFFFF, 24'd8388608,
                  24'd2097152, 1'b0);
        queue_item({24'h800000, 24'h000000});
        queue_item({24'h000000, 24'h7FFFFF});

        for (k = 0; k < 12; k++)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
                rmode = MODE_TRIGGERED;
            else if (pick < 70)
                rmode = MODE_INVERTED;
            else if (pick < 85)
                rmode = MODE_WHAMMY;
            else
                rmode = MODE_FREE;
            write_all(rmode,
                      25'(skewed_value(0, 33554431, 1048576, 16777216)),
                      24'(skewed_value(0, 16777215, 131072, 4194304)),
                      24'(skewed_value(0, 16777215, 131072, 4194304)),
                      16'(skewed_value(0, 65535, 300, 40000)),
                      24'(skewed_value(0, 16777215, 0, 8388608)),
                      24'(skewed_value(0, 16777215, 2097152, 8388608)),
                      1'($urandom_range(1)));
            calm = (k == 5);
            n = 0;
            while (n < 104)
                n += queue_run();
        end

        drain();
        if (mismatch_cnt == 0 && expected_sweeps.size() == 0)
            $display("envelope_triggered_pitch_sweep_top_tb: clean");
        else
            $display("envelope_triggered_pitch_sweep_top_tb: errors");
        $finish;
    end

endmodule
